[rtl/bva_pkg.sv]
// ----------------------------------------------------------------------------
// bva_pkg
// Shared widths, constants and types of the block variance accumulator.
// ----------------------------------------------------------------------------
package bva_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int VAR_W       = 41;
    localparam int PROD_W      = 64;
    localparam int MUL_B_W     = 27;
    localparam int DIGIT_W     = 2;
    localparam int DIV_W       = 21;
    localparam int DIV_CNT_W   = 6;
    localparam int DENOM_SHIFT = 8;

    // square of the 9375/4096 scale numerator
    localparam logic [MUL_B_W-1:0] SCALE_SQ = 27'd87890625;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM_SQ,
        ST_SPREAD,
        ST_SCALE,
        ST_DIVIDE
    } bva_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bva_unit_status_t;

endpackage

[rtl/bva_if.sv]
// ----------------------------------------------------------------------------
// bva_if
// Valid/ready channels for the sample words and the variance words.
// ----------------------------------------------------------------------------
interface bva_sample_if
    import bva_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface bva_result_if
    import bva_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAR_W-1:0] block_variance;

    modport source (output valid, output block_variance, input ready);
    modport sink   (input valid, input block_variance, output ready);
endinterface

[rtl/bva_serial_mul.sv]
// ----------------------------------------------------------------------------
// bva_serial_mul
// Shift-add multiplier taking two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module bva_serial_mul
    import bva_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PROD_W-1:0]  mcand,
    input  logic [MUL_B_W-1:0] mplier,
    output bva_unit_status_t   status,
    output logic [PROD_W-1:0]  product
);

    logic               busy_reg;
    logic               busy_next;
    logic [PROD_W-1:0]  mcand_reg;
    logic [PROD_W-1:0]  mcand_next;
    logic [MUL_B_W-1:0] mplier_reg;
    logic [MUL_B_W-1:0] mplier_next;
    logic [PROD_W-1:0]  product_reg;
    logic [PROD_W-1:0]  product_next;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  partial;

    assign digit   = mplier_reg[DIGIT_W-1:0];
    assign partial = (digit[0] ? mcand_reg : '0)
                   + (digit[1] ? {mcand_reg[PROD_W-2:0], 1'b0} : '0);

    always_comb
    begin
        busy_next    = busy_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        product_next = product_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            mcand_next   = mcand;
            mplier_next  = mplier;
            product_next = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                product_next = product_reg + partial;
                mcand_next   = mcand_reg << DIGIT_W;
                mplier_next  = mplier_reg >> DIGIT_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        product_reg <= product_next;
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (mplier_reg == '0);
    assign product     = product_reg;

endmodule

[rtl/bva_serial_div.sv]
// ----------------------------------------------------------------------------
// bva_serial_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bva_serial_div
    import bva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output bva_unit_status_t  status,
    output logic [PROD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [PROD_W-1:0]    quot_reg;
    logic [PROD_W-1:0]    quot_next;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, quot_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[PROD_W-2:0], fits};
            rem_next  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;

endmodule

[rtl/block_variance_accumulator.sv]
// ----------------------------------------------------------------------------
// block_variance_accumulator
// Population variance of 9375/4096-scaled sensor samples over fixed blocks.
// ----------------------------------------------------------------------------
// Takes one 12-bit raw sample word at a time and emits one 41-bit unsigned
// Q.16 variance word (truncated) after every BLOCK_SIZE samples, then starts
// a fresh block. Sample squares go through a shared two-bit-per-cycle
// shift-add multiplier, which finishes sooner for small readings; no new
// sample is taken until the square is done. On the last sample of a block
// the sum is squared and the spread scaled in that same multiplier, and
// then the constant divide by N*N*256 runs one quotient bit per cycle.
// A finished word waits in an output register while the next block fills.
// ----------------------------------------------------------------------------
module block_variance_accumulator
    import bva_pkg::*;
#(
    parameter int BLOCK_SIZE = 12
)
(
    input logic          clk,
    input logic          rst_n,
    bva_sample_if.sink   sample,
    bva_result_if.source result
);

    localparam int LOG_N    = $clog2(BLOCK_SIZE);
    localparam int CNT_W    = LOG_N;
    localparam int SUM_W    = SAMPLE_W + LOG_N;
    localparam int SQ_W     = 2 * SAMPLE_W + LOG_N;
    localparam int SPREAD_W = SQ_W + $clog2(BLOCK_SIZE + 1);
    localparam int DENOM    = BLOCK_SIZE * BLOCK_SIZE * (2 ** DENOM_SHIFT);
    localparam int LAST_CNT = BLOCK_SIZE - 1;

    bva_state_t          state_reg;
    bva_state_t          state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SQ_W-1:0]     sumsq_reg;
    logic [SQ_W-1:0]     sumsq_next;
    logic [SPREAD_W-1:0] spread_reg;
    logic [SPREAD_W-1:0] spread_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VAR_W-1:0]    out_data_reg;
    logic [VAR_W-1:0]    out_data_next;

    logic                accept;
    logic                block_end;
    logic                mul_start;
    logic [PROD_W-1:0]   mul_mcand;
    logic [MUL_B_W-1:0]  mul_mplier;
    bva_unit_status_t    mul_status;
    logic [PROD_W-1:0]   mul_product;
    logic                div_start;
    bva_unit_status_t    div_status;
    logic [PROD_W-1:0]   div_quot;
    logic                out_load;

    bva_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .status  (mul_status),
        .product (mul_product)
    );

    bva_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (DIV_W'(DENOM)),
        .status   (div_status),
        .quotient (div_quot)
    );

    assign sample.ready         = (state_reg == ST_IDLE);
    assign accept               = sample.valid && sample.ready;
    assign block_end            = (cnt_reg == CNT_W'(LAST_CNT));
    assign result.valid         = out_valid_reg;
    assign result.block_variance = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mul_status.done)
                begin
                    state_next = block_end ? ST_SUM_SQ : ST_IDLE;
                end
            end
            ST_SUM_SQ:
            begin
                if (mul_status.done)
                begin
                    state_next = ST_SPREAD;
                end
            end
            ST_SPREAD:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (mul_status.done)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // unit control
    always_comb
    begin
        mul_start  = 1'b0;
        mul_mcand  = PROD_W'(sample.raw_sample);
        mul_mplier = MUL_B_W'(sample.raw_sample);
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mul_start = accept;
            end
            ST_SQUARE:
            begin
                mul_start  = mul_status.done && block_end;
                mul_mcand  = PROD_W'(sum_reg);
                mul_mplier = MUL_B_W'(sum_reg);
            end
            ST_SPREAD:
            begin
                mul_start  = 1'b1;
                mul_mcand  = PROD_W'(spread_reg);
                mul_mplier = SCALE_SQ;
            end
            ST_SCALE:
            begin
                div_start = mul_status.done;
            end
            ST_DIVIDE:
            begin
                out_load = div_status.done && (!out_valid_reg || result.ready);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // accumulators and output word
    always_comb
    begin
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        spread_next    = spread_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            sum_next = sum_reg + SUM_W'(sample.raw_sample);
        end
        if ((state_reg == ST_SQUARE) && mul_status.done)
        begin
            sumsq_next = sumsq_reg + mul_product[SQ_W-1:0];
            cnt_next   = block_end ? '0 : cnt_reg + 1'b1;
        end
        if ((state_reg == ST_SUM_SQ) && mul_status.done)
        begin
            spread_next = SPREAD_W'(BLOCK_SIZE) * SPREAD_W'(sumsq_reg)
                        - mul_product[SPREAD_W-1:0];
            sum_next    = '0;
            sumsq_next  = '0;
        end
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = div_quot[VAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            sumsq_reg     <= sumsq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spread_reg   <= spread_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_ready_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> (!mul_status.busy && !div_status.busy))
        else $error("sample taken while an arithmetic unit is busy");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LAST_CNT))
        else $error("sample count beyond block size");

    a_div_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> ((state_reg == ST_SCALE) && mul_status.done))
        else $error("divider started without a scaled spread");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (div_quot[PROD_W-1:VAR_W] == '0))
        else $error("variance quotient exceeds output width");

    a_load_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("variance word lost on load");
`endif

endmodule
